/* design/nfs_pkg.sv */
// Shared types, widths and defaults for the non-negative filter and sort block.
`timescale 1ns / 1ps

package nfs_pkg;

  // Width of one incoming signed sample and of the kept magnitude.
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned MAG_BITS   = VALUE_BITS - 1;

  // Default number of values held per set.
  localparam int unsigned CAPACITY = 16;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample;
    logic                         set_end;
  } in_item_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] sorted_value;
    logic                final_value;
    logic                none_kept;
    logic                overflowed;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // input beat accepted this cycle
    logic pop;   // output beat accepted this cycle
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_out;  // the head result is the final one of the run
  } dp_status_t;

endpackage

/* design/nonnegative_filter_sort.sv */
// Top level: drops negative samples, sorts the rest and streams them out.
// Output: the first result beat is valid in the cycle after the set_end beat is taken.
// Throughput: one input beat per cycle while collecting, then one result beat
//   per cycle while out_stall_i is low; a single row of insertion cells both
//   fills and drains.
// Reset: asynchronous, active low; clears the state, kept count and overflow
//   flag. The value cells are not reset and are only read below the count.
`timescale 1ns / 1ps

module nonnegative_filter_sort #(
  parameter int unsigned CAPACITY = nfs_pkg::CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nfs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nfs_pkg::out_item_t out_data_o
);

  nfs_pkg::ctrl_cmd_t  cmd;
  nfs_pkg::dp_status_t st;

  // The controller alternates between taking a set and draining it. While
  // a set is drained the input side is stalled, so one beat moves per cycle
  // on at most one side.
  nfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.set_end),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // Each non-negative sample drops into its place in an ascending row of
  // cells in the cycle it arrives; the row shifts towards the head as each
  // result beat leaves, so the head cell is always the next result.
  nfs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .st_o       (st),
    .out_data_o (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // Never take an input beat while a result is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o && out_valid_o))
    else $error("input taken while draining");

  // Results of one run leave in ascending order.
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.final_value) |=>
      (out_valid_o && (out_data_o.sorted_value >= $past(out_data_o.sorted_value))))
    else $error("results out of order");

  // The final beat closes the run.
  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.final_value) |=> !out_valid_o)
    else $error("results continue after final beat");

  // An empty run is a single zero beat.
  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.none_kept) |->
      (out_data_o.final_value && (out_data_o.sorted_value == '0)))
    else $error("malformed empty result");
`endif

endmodule

/* design/nfs_datapath.sv */
// Datapath: row of insertion cells, kept count, overflow flag and result head.
`timescale 1ns / 1ps

module nfs_datapath #(
  parameter int unsigned CAPACITY = nfs_pkg::CAPACITY
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nfs_pkg::ctrl_cmd_t    cmd_i,
  input  nfs_pkg::in_item_t     in_data_i,
  output nfs_pkg::dp_status_t   st_o,
  output nfs_pkg::out_item_t    out_data_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [nfs_pkg::MAG_BITS-1:0] cell_q [CAPACITY];
  logic [nfs_pkg::MAG_BITS-1:0] cell_d [CAPACITY];
  logic [CntW-1:0]              count_q, count_d;
  logic                         ovf_q, ovf_d;

  logic [CAPACITY-1:0]          ahead;
  logic [nfs_pkg::MAG_BITS-1:0] new_val;
  logic                         keep_new;
  logic                         empty;

  assign new_val  = in_data_i.sample[nfs_pkg::MAG_BITS-1:0];
  assign keep_new = cmd_i.take && !in_data_i.sample[nfs_pkg::VALUE_BITS-1];
  assign empty    = (count_q == '0);

  // A cell is "ahead" when the new value belongs at or before it.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ahead[i] = (CntW'(i) >= count_q) || (new_val < cell_q[i]);
    end
  end

  always_comb begin
    cell_d  = cell_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    priority if (cmd_i.pop) begin
      // advance the row towards the head
      for (int i = 0; i < CAPACITY - 1; i++) begin
        cell_d[i] = cell_q[i+1];
      end
      if (!empty) begin
        count_d = count_q - CntW'(1);
      end
      if (st_o.last_out) begin
        ovf_d = 1'b0;
      end
    end else if (keep_new) begin
      if (count_q < CntW'(CAPACITY)) begin
        if (ahead[0]) begin
          cell_d[0] = new_val;
        end
        for (int i = 1; i < CAPACITY; i++) begin
          if (ahead[i]) begin
            cell_d[i] = ahead[i-1] ? cell_q[i-1] : new_val;
          end
        end
        count_d = count_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end else begin
      ovf_d = ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign st_o.last_out = (count_q <= CntW'(1));

  assign out_data_o.sorted_value = empty ? '0 : cell_q[0];
  assign out_data_o.final_value  = st_o.last_out;
  assign out_data_o.none_kept    = empty;
  assign out_data_o.overflowed   = ovf_q;

endmodule

/* design/nfs_ctrl.sv */
// Controller: collect/drain state machine and handshake control.
`timescale 1ns / 1ps

module nfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  nfs_pkg::dp_status_t st_i,
  output nfs_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_COLLECT = 2'b01,
    S_DRAIN   = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o  = (state_q != S_COLLECT);
  assign out_valid_o = (state_q == S_DRAIN);
  assign cmd_o.take  = (state_q == S_COLLECT) && in_valid_i;
  assign cmd_o.pop   = (state_q == S_DRAIN) && !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_COLLECT: begin
        if (cmd_o.take && in_last_i) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cmd_o.pop && st_i.last_out) begin
          state_d = S_COLLECT;
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* test/tb_nonnegative_filter_sort.sv */
// Self-checking testbench for the non-negative filter and sort block.
`timescale 1ns / 1ps

module tb_nonnegative_filter_sort;

  localparam int unsigned VALUE_BITS = nfs_pkg::VALUE_BITS;
  localparam int unsigned MAG_BITS   = nfs_pkg::MAG_BITS;
  localparam int unsigned CAPACITY   = nfs_pkg::CAPACITY;

  typedef nfs_pkg::in_item_t  in_item_t;
  typedef nfs_pkg::out_item_t out_item_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AFTER_BEATS = 100;  // input beats before the long hold
  localparam int unsigned HOLD_CYCLES = 300;       // length of the long hold
  localparam int unsigned SETTLE_CYCLES = 20;      // quiet time after the last result

  // One queued input beat, with the idle cycles to spend before offering it and
  // whether to wait for every due result first.
  typedef struct {
    in_item_t    beat;
    int unsigned gap;
    bit          drain_first;
  } pending_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // Stimulus waiting to be offered, and results the block still owes.
  pending_t  pending_beats[$];
  out_item_t sorted_due[$];

  // Predictor state: values kept so far in the open set, and the spill flag.
  logic [MAG_BITS-1:0] kept_vals[CAPACITY];
  int unsigned         kept_n = 0;
  logic                spill_seen = 1'b0;

  int unsigned mismatches = 0;
  int unsigned beats_checked = 0;
  int unsigned cycle_count = 0;
  logic        rx_hold = 1'b0;

  nonnegative_filter_sort DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Print one line per mismatch (the first few only) and count every one.
  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("result beat %0d: %s got %0d, want %0d", beats_checked, field, got, want);
    end
  endtask

  // Fold one accepted input beat into the predictor. Keep non-negative samples
  // up to capacity and flag any that spill; on the set's last beat, sort what
  // was kept and queue the results, or a single empty result if nothing was.
  function automatic void absorb_sample(in_item_t beat);
    out_item_t           res;
    logic [MAG_BITS-1:0] tmp;
    int                  i;
    int                  k;
    if (!beat.sample[VALUE_BITS-1]) begin
      if (kept_n < CAPACITY) begin
        kept_vals[kept_n] = beat.sample[MAG_BITS-1:0];
        kept_n++;
      end else begin
        spill_seen = 1'b1;
      end
    end
    if (beat.set_end) begin
      if (kept_n == 0) begin
        res.sorted_value = '0;
        res.final_value  = 1'b1;
        res.none_kept    = 1'b1;
        res.overflowed   = spill_seen;
        sorted_due.push_back(res);
      end else begin
        for (i = 1; i < int'(kept_n); i++) begin
          tmp = kept_vals[i];
          k = i;
          while (k > 0 && kept_vals[k-1] > tmp) begin
            kept_vals[k] = kept_vals[k-1];
            k--;
          end
          kept_vals[k] = tmp;
        end
        for (i = 0; i < int'(kept_n); i++) begin
          res.sorted_value = kept_vals[i];
          res.final_value  = (i == int'(kept_n) - 1);
          res.none_kept    = 1'b0;
          res.overflowed   = spill_seen;
          sorted_due.push_back(res);
        end
      end
      kept_n = 0;
      spill_seen = 1'b0;
    end
  endfunction

  // Draw a sample: a share negative, a share of small values to force
  // duplicates, a share of the range ends, the rest anywhere in 16 bits.
  function automatic logic signed [VALUE_BITS-1:0] draw_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: draw_sample = VALUE_BITS'(-int'($urandom_range(1, 32768)));
      3:       draw_sample = VALUE_BITS'($urandom_range(0, 7));
      4: begin
        case ($urandom_range(0, 3))
          0:       draw_sample = 16'sh0000;
          1:       draw_sample = 16'sh7fff;
          2:       draw_sample = -16'sd1;
          default: draw_sample = 16'sh8000;
        endcase
      end
      default: draw_sample = VALUE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_beat(int sample, bit last, int unsigned gap, bit drain_first);
    pending_t p;
    p.beat.sample  = VALUE_BITS'(sample);
    p.beat.set_end = last;
    p.gap          = gap;
    p.drain_first  = drain_first;
    pending_beats.push_back(p);
  endtask

  // Fill the stimulus queue, then wait for the run to settle and give the verdict.
  initial begin
    int unsigned n_sets;
    int unsigned len;
    int unsigned j;
    int unsigned gap;
    bit          quiet_set;

    // Directed sets. Range ends followed by a zero.
    queue_beat(32767, 1'b0, 0, 1'b0);
    queue_beat(-32768, 1'b0, 0, 1'b0);
    queue_beat(0, 1'b1, 0, 1'b0);
    // Empty set of a single negative, then a lone zero, then all negatives.
    queue_beat(-1, 1'b1, 3, 1'b0);
    queue_beat(0, 1'b1, 0, 1'b0);
    queue_beat(-300, 1'b0, 17, 1'b0);
    queue_beat(-32768, 1'b1, 1, 1'b0);
    // Store full: fourteen descending values and a duplicated pair fill it,
    // the next non-negative one spills, a negative closes the set.
    for (j = 0; j < 14; j++) begin
      queue_beat(32767 - j * 1000, 1'b0, $urandom_range(0, 17), 1'b0);
    end
    queue_beat(5, 1'b0, 0, 1'b0);
    queue_beat(5, 1'b0, 0, 1'b0);
    queue_beat(9, 1'b0, 2, 1'b0);
    queue_beat(-2, 1'b1, 0, 1'b0);

    // Random sets, mostly short, now and then long enough to spill.
    n_sets = 0;
    while (pending_beats.size() < 310) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 8);
      quiet_set = ($urandom_range(0, 3) == 0);
      for (j = 0; j < len; j++) begin
        // Keep the sender busy around the long receiver hold so the block fills.
        if (pending_beats.size() >= 80 && pending_beats.size() < 200) begin
          gap = $urandom_range(0, 1);
        end else if (quiet_set) begin
          gap = 0;
        end else begin
          gap = $urandom_range(0, 17);
        end
        queue_beat(int'(draw_sample()), j == len - 1, gap, j == 0 && n_sets % 6 == 0);
      end
      n_sets++;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Input driver: hold a stalled beat, record an accepted one in the predictor,
  // then idle out the next beat's gap before offering it.
  always @(posedge clk_i) begin : drive_in
    logic next_valid;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        absorb_sample(in_data_i);
      end
      if (!(in_valid_i && in_stall_o)) begin
        next_valid = 1'b0;
        if (pending_beats.size() != 0) begin
          if (pending_beats[0].gap != 0) begin
            pending_beats[0].gap--;
          end else if (!pending_beats[0].drain_first || sorted_due.size() == 0) begin
            in_data_i <= pending_beats[0].beat;
            void'(pending_beats.pop_front());
            next_valid = 1'b1;
          end
        end
        in_valid_i <= next_valid;
      end
    end
  end

  // Long receiver hold: once enough input beats have gone in, stall the output
  // for a fixed stretch so the block fills up or, while draining, holds its input stalled.
  always @(posedge clk_i) begin : long_hold
    int unsigned beats_in;
    int unsigned hold_left;
    bit          hold_done;
    if (!rst_ni) begin
      beats_in = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) beats_in++;
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && beats_in >= HOLD_AFTER_BEATS) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      rx_hold <= (hold_left != 0);
    end
  end

  // Output monitor: check each accepted result beat against the oldest one due,
  // then draw the stall before the next; some stretches run without stalls.
  always @(posedge clk_i) begin : watch_out
    out_item_t   want;
    int unsigned rx_wait;
    logic        stall_next;
    if (!rst_ni) begin
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (sorted_due.size() == 0) begin
          report_mismatch("beat with nothing due, sorted_value",
                          int'(out_data_o.sorted_value), 0);
        end else begin
          want = sorted_due.pop_front();
          if (out_data_o.sorted_value !== want.sorted_value)
            report_mismatch("sorted_value", int'(out_data_o.sorted_value),
                            int'(want.sorted_value));
          if (out_data_o.final_value !== want.final_value)
            report_mismatch("final_value", int'(out_data_o.final_value),
                            int'(want.final_value));
          if (out_data_o.none_kept !== want.none_kept)
            report_mismatch("none_kept", int'(out_data_o.none_kept),
                            int'(want.none_kept));
          if (out_data_o.overflowed !== want.overflowed)
            report_mismatch("overflowed", int'(out_data_o.overflowed),
                            int'(want.overflowed));
        end
        beats_checked++;
        rx_wait = ((beats_checked / 40) % 4 == 0) ? 0 : $urandom_range(0, 17);
      end
      stall_next = 1'b0;
      if (rx_wait != 0) begin
        rx_wait--;
        stall_next = 1'b1;
      end
      out_stall_i <= stall_next || rx_hold;
    end
  end

  // Watchdog: give up if the run has not finished by the limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
